@@ rtl/core/uvs_pkg.sv @@
// Shared types and constants of the UV sphere cell vertex generator.
// No dependencies; every other file of the block imports this package.
package uvs_pkg;

	localparam int IDX_BITS = 8;
	localparam int CNT_BITS = 9;
	localparam int RADIUS_BITS = 16;
	localparam int VNUM_BITS = 19;
	localparam int CORNER_BITS = 3;
	localparam int PHASE_BITS = 32;
	localparam int NUM_BITS = 41;
	localparam int CORDIC_W = 34;
	localparam int CORDIC_STEPS = 32;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

	localparam logic [PHASE_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	// Bit k tells whether corner k steps to the next ring or next slice.
	localparam logic [5:0] CORNER_DL = 6'b110100;
	localparam logic [5:0] CORNER_DS = 6'b010110;
	localparam logic [CORNER_BITS-1:0] CORNER_FIRST = 3'd0;
	localparam logic [CORNER_BITS-1:0] CORNER_LAST = 3'd5;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 16'd256;
	localparam logic [CNT_BITS-1:0] SLICE_RESET = 9'd16;
	localparam logic [CNT_BITS-1:0] LAYER_RESET = 9'd8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SPHERE_RADIUS = 2'd0,
		REG_SLICE_COUNT = 2'd1,
		REG_LAYER_COUNT = 2'd2
	} uvs_reg_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] layer_index;
		logic [IDX_BITS-1:0] slice_index;
	} uvs_in_t;

	typedef struct packed {
		logic signed [23:0] vertex_x;
		logic signed [23:0] vertex_y;
		logic signed [23:0] vertex_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [VNUM_BITS-1:0] vertex_number;
		logic [CORNER_BITS-1:0] corner;
		logic out_of_range;
		logic last_corner;
	} uvs_out_t;

	typedef struct packed {
		logic [VNUM_BITS-1:0] vertex_number;
		logic [CORNER_BITS-1:0] corner;
		logic out_of_range;
		logic last_corner;
	} uvs_meta_t;

endpackage

@@ rtl/core/uvs_div.sv @@
// Pipelined restoring divider with two lanes, one quotient bit per stage.
// Depends on uvs_pkg; yields the low phase bits of round-to-nearest angle quotients.
module uvs_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  logic [uvs_pkg::NUM_BITS-1:0]     pol_num,
	input  logic [uvs_pkg::CNT_BITS-1:0]     pol_den,
	input  logic [uvs_pkg::NUM_BITS-1:0]     azi_num,
	input  logic [uvs_pkg::CNT_BITS-1:0]     azi_den,
	input  uvs_pkg::uvs_meta_t               in_meta,
	output logic                             out_valid,
	output logic [uvs_pkg::PHASE_BITS-1:0]   pol_quo,
	output logic [uvs_pkg::PHASE_BITS-1:0]   azi_quo,
	output uvs_pkg::uvs_meta_t               out_meta
);
	import uvs_pkg::*;

	logic [CNT_BITS-1:0] pr_s [NUM_BITS];
	logic [CNT_BITS-1:0] pd_s [NUM_BITS];
	logic [NUM_BITS-1:0] pn_s [NUM_BITS];
	logic [PHASE_BITS-1:0] pq_s [NUM_BITS];
	logic [CNT_BITS-1:0] ar_s [NUM_BITS];
	logic [CNT_BITS-1:0] ad_s [NUM_BITS];
	logic [NUM_BITS-1:0] an_s [NUM_BITS];
	logic [PHASE_BITS-1:0] aq_s [NUM_BITS];
	uvs_meta_t meta_s [NUM_BITS];
	logic vld_s [NUM_BITS];

	for (genvar g = 0; g < NUM_BITS; g++) begin : g_step
		logic [CNT_BITS-1:0] pr, pd, ar, ad;
		logic [NUM_BITS-1:0] pn, an;
		logic [PHASE_BITS-1:0] pq, aq;
		uvs_meta_t m;
		logic v;
		logic [CNT_BITS:0] pt, at;
		logic pge, age;

		if (g == 0) begin : g_first
			assign pr = '0;
			assign pd = pol_den;
			assign pn = pol_num;
			assign pq = '0;
			assign ar = '0;
			assign ad = azi_den;
			assign an = azi_num;
			assign aq = '0;
			assign m = in_meta;
			assign v = in_valid;
		end else begin : g_next
			assign pr = pr_s[g-1];
			assign pd = pd_s[g-1];
			assign pn = pn_s[g-1];
			assign pq = pq_s[g-1];
			assign ar = ar_s[g-1];
			assign ad = ad_s[g-1];
			assign an = an_s[g-1];
			assign aq = aq_s[g-1];
			assign m = meta_s[g-1];
			assign v = vld_s[g-1];
		end

		assign pt = {pr, pn[NUM_BITS-1]};
		assign at = {ar, an[NUM_BITS-1]};
		assign pge = pt >= {1'b0, pd};
		assign age = at >= {1'b0, ad};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pr_s[g] <= pge ? CNT_BITS'(pt - {1'b0, pd}) : pt[CNT_BITS-1:0];
				ar_s[g] <= age ? CNT_BITS'(at - {1'b0, ad}) : at[CNT_BITS-1:0];
				pq_s[g] <= {pq[PHASE_BITS-2:0], pge};
				aq_s[g] <= {aq[PHASE_BITS-2:0], age};
				pn_s[g] <= {pn[NUM_BITS-2:0], 1'b0};
				an_s[g] <= {an[NUM_BITS-2:0], 1'b0};
				pd_s[g] <= pd;
				ad_s[g] <= ad;
				meta_s[g] <= m;
			end
		end
	end

	assign out_valid = vld_s[NUM_BITS-1];
	assign pol_quo = pq_s[NUM_BITS-1];
	assign azi_quo = aq_s[NUM_BITS-1];
	assign out_meta = meta_s[NUM_BITS-1];

endmodule

@@ rtl/core/uvs_cordic.sv @@
// Pipelined rotation CORDIC with two lanes, one micro-rotation per stage.
// Depends on uvs_pkg for the arctangent table and the gain constant.
module uvs_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [uvs_pkg::PHASE_BITS-1:0]       pol_phase,
	input  logic [uvs_pkg::PHASE_BITS-1:0]       azi_phase,
	input  uvs_pkg::uvs_meta_t                   in_meta,
	output logic                                 out_valid,
	output logic signed [uvs_pkg::CORDIC_W-1:0]  pol_x,
	output logic signed [uvs_pkg::CORDIC_W-1:0]  pol_y,
	output logic [1:0]                           pol_quad,
	output logic signed [uvs_pkg::CORDIC_W-1:0]  azi_x,
	output logic signed [uvs_pkg::CORDIC_W-1:0]  azi_y,
	output logic [1:0]                           azi_quad,
	output uvs_pkg::uvs_meta_t                   out_meta
);
	import uvs_pkg::*;

	logic signed [CORDIC_W-1:0] px_s [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] py_s [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] pz_s [CORDIC_STEPS];
	logic [1:0] pq_s [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] ax_s [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] ay_s [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] az_s [CORDIC_STEPS];
	logic [1:0] aq_s [CORDIC_STEPS];
	uvs_meta_t meta_s [CORDIC_STEPS];
	logic vld_s [CORDIC_STEPS];

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
		localparam logic signed [CORDIC_W-1:0] ANG = CORDIC_W'(ATAN_TURNS[g]);
		logic signed [CORDIC_W-1:0] px, py, pz, ax, ay, az;
		logic [1:0] pq, aq;
		uvs_meta_t m;
		logic v;

		if (g == 0) begin : g_first
			assign px = CORDIC_GAIN;
			assign py = '0;
			assign pz = CORDIC_W'(pol_phase[PHASE_BITS-3:0]);
			assign pq = pol_phase[PHASE_BITS-1:PHASE_BITS-2];
			assign ax = CORDIC_GAIN;
			assign ay = '0;
			assign az = CORDIC_W'(azi_phase[PHASE_BITS-3:0]);
			assign aq = azi_phase[PHASE_BITS-1:PHASE_BITS-2];
			assign m = in_meta;
			assign v = in_valid;
		end else begin : g_next
			assign px = px_s[g-1];
			assign py = py_s[g-1];
			assign pz = pz_s[g-1];
			assign pq = pq_s[g-1];
			assign ax = ax_s[g-1];
			assign ay = ay_s[g-1];
			assign az = az_s[g-1];
			assign aq = aq_s[g-1];
			assign m = meta_s[g-1];
			assign v = vld_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!pz[CORDIC_W-1]) begin
					px_s[g] <= px - (py >>> g);
					py_s[g] <= py + (px >>> g);
					pz_s[g] <= pz - ANG;
				end else begin
					px_s[g] <= px + (py >>> g);
					py_s[g] <= py - (px >>> g);
					pz_s[g] <= pz + ANG;
				end
				if (!az[CORDIC_W-1]) begin
					ax_s[g] <= ax - (ay >>> g);
					ay_s[g] <= ay + (ax >>> g);
					az_s[g] <= az - ANG;
				end else begin
					ax_s[g] <= ax + (ay >>> g);
					ay_s[g] <= ay - (ax >>> g);
					az_s[g] <= az + ANG;
				end
				pq_s[g] <= pq;
				aq_s[g] <= aq;
				meta_s[g] <= m;
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign pol_x = px_s[CORDIC_STEPS-1];
	assign pol_y = py_s[CORDIC_STEPS-1];
	assign pol_quad = pq_s[CORDIC_STEPS-1];
	assign azi_x = ax_s[CORDIC_STEPS-1];
	assign azi_y = ay_s[CORDIC_STEPS-1];
	assign azi_quad = aq_s[CORDIC_STEPS-1];
	assign out_meta = meta_s[CORDIC_STEPS-1];

endmodule

@@ rtl/core/uv_sphere_cell_vertex_generator.sv @@
// Top level of the UV sphere cell vertex generator.
// Depends on uvs_pkg, uvs_div and uvs_cordic.

// One request carries a (layer, slice) cell and yields six corner results, one per
// cycle while the result side does not stall; the single result port bounds the cell
// rate. A cell is taken while the previous one is still issuing its
// last corner. On the way to the first corner of a cell, the issue register loads on
// the accepting edge, then come 41 divider stages for the angles, 32 CORDIC stages
// and four stages of rounding, scaling and saturation.
// A stall on the result side holds the whole pipeline and nothing is lost.
module uv_sphere_cell_vertex_generator #(
	parameter int MAX_SLICES = 256,
	parameter int MAX_LAYERS = 256,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  uvs_pkg::uvs_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output uvs_pkg::uvs_out_t                   out_data,
	input  logic                                cfg_we,
	input  logic [uvs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [uvs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import uvs_pkg::*;

	localparam int T = TRIG_FRAC_BITS;
	localparam int TW = T + 2;
	localparam int TSH = 30 - T;
	localparam logic [CORDIC_W:0] THALF = (CORDIC_W+1)'((64'(1) << TSH) >> 1);
	localparam logic signed [CORDIC_W:0] TONE = (CORDIC_W+1)'(64'(1) << T);
	localparam int PW = 2 * TW;
	localparam logic [PW-1:0] PHALF = PW'((64'(1) << T) >> 1);
	localparam int NQW = TW + 16;
	localparam int NSH_R = (T >= 15) ? T - 15 : 0;
	localparam int NSH_L = (T >= 15) ? 0 : 15 - T;
	localparam logic [NQW-1:0] NHALF = NQW'((64'(1) << NSH_R) >> 1);
	localparam int PVW = TW + RADIUS_BITS + 1;
	localparam int VSH = T - 7;
	localparam logic [PVW-1:0] VHALF = PVW'((64'(1) << VSH) >> 1);

	logic [RADIUS_BITS-1:0] radius_q;
	logic [CNT_BITS-1:0] slice_cnt_q, layer_cnt_q;
	logic [CNT_BITS-1:0] ns, nl;

	logic en, accept;
	logic cell_vld_q;
	logic [IDX_BITS-1:0] layer_q, slice_q;
	logic oor_q;
	logic [VNUM_BITS-2:0] base_q;
	logic [CORNER_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] ring, seg;
	logic [NUM_BITS-1:0] pol_num, azi_num;
	uvs_meta_t issue_meta;

	logic div_vld;
	logic [PHASE_BITS-1:0] pol_quo, azi_quo;
	uvs_meta_t div_meta;

	logic cor_vld;
	logic signed [CORDIC_W-1:0] pol_x, pol_y, azi_x, azi_y;
	logic [1:0] pol_quad, azi_quad;
	uvs_meta_t cor_meta;

	logic vld_s1, vld_s2, vld_s3;
	uvs_meta_t meta_s1, meta_s2, meta_s3;
	logic signed [TW-1:0] pc_s1, ps_s1, ac_s1, as_s1;
	logic signed [TW-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [PVW-1:0] pvx_s3, pvy_s3, pvz_s3;
	logic signed [15:0] nx_s3, ny_s3, nz_s3;
	logic vld_s4;
	uvs_out_t out_s4;

	function automatic logic signed [CORDIC_W-1:0] fold_cos(
		input logic [1:0] q, input logic signed [CORDIC_W-1:0] x,
		input logic signed [CORDIC_W-1:0] y);
		logic signed [CORDIC_W-1:0] r;
		case (q)
			2'd0: r = x;
			2'd1: r = -y;
			2'd2: r = -x;
			default: r = y;
		endcase
		return r;
	endfunction

	function automatic logic signed [CORDIC_W-1:0] fold_sin(
		input logic [1:0] q, input logic signed [CORDIC_W-1:0] x,
		input logic signed [CORDIC_W-1:0] y);
		logic signed [CORDIC_W-1:0] r;
		case (q)
			2'd0: r = y;
			2'd1: r = x;
			2'd2: r = -y;
			default: r = -x;
		endcase
		return r;
	endfunction

	function automatic logic signed [TW-1:0] trig_round(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W:0] r;
		r = ($signed({v[CORDIC_W-1], v}) + $signed(THALF)) >>> TSH;
		if (r > TONE) begin
			r = TONE;
		end else if (r < -TONE) begin
			r = -TONE;
		end
		return TW'(r);
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [TW-1:0] d);
		logic signed [NQW-1:0] e;
		e = NQW'(d);
		e = ((e <<< NSH_L) + $signed(NHALF)) >>> NSH_R;
		if (e > $signed(NQW'(32767))) begin
			e = NQW'(32767);
		end else if (e < -$signed(NQW'(32768))) begin
			e = -$signed(NQW'(32768));
		end
		return 16'(e);
	endfunction

	function automatic logic signed [23:0] to_vertex(input logic signed [PVW-1:0] p);
		logic signed [PVW-1:0] e;
		e = (p + $signed(VHALF)) >>> VSH;
		if (e > $signed(PVW'(8388607))) begin
			e = PVW'(8388607);
		end else if (e < -$signed(PVW'(8388608))) begin
			e = -$signed(PVW'(8388608));
		end
		return 24'(e);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			slice_cnt_q <= SLICE_RESET;
			layer_cnt_q <= LAYER_RESET;
		end else if (cfg_we) begin
			case (uvs_reg_t'(cfg_index))
				REG_SPHERE_RADIUS: radius_q <= cfg_data;
				REG_SLICE_COUNT: slice_cnt_q <= cfg_data[CNT_BITS-1:0];
				REG_LAYER_COUNT: layer_cnt_q <= cfg_data[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (slice_cnt_q == '0) begin
			ns = CNT_BITS'(1);
		end else if (32'(slice_cnt_q) > MAX_SLICES) begin
			ns = CNT_BITS'(MAX_SLICES);
		end else begin
			ns = slice_cnt_q;
		end
		if (layer_cnt_q == '0) begin
			nl = CNT_BITS'(1);
		end else if (32'(layer_cnt_q) > MAX_LAYERS) begin
			nl = CNT_BITS'(MAX_LAYERS);
		end else begin
			nl = layer_cnt_q;
		end
	end

	assign en = !vld_s4 || !out_stall;
	assign in_stall = cell_vld_q && !(en && cnt_q == CORNER_LAST);
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= 1'b0;
			cnt_q <= CORNER_FIRST;
		end else if (accept) begin
			cell_vld_q <= 1'b1;
			cnt_q <= CORNER_FIRST;
		end else if (en && cell_vld_q) begin
			if (cnt_q == CORNER_LAST) begin
				cell_vld_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			layer_q <= in_data.layer_index;
			slice_q <= in_data.slice_index;
			oor_q <= (CNT_BITS'(in_data.layer_index) >= nl) ||
				(CNT_BITS'(in_data.slice_index) >= ns);
			base_q <= (VNUM_BITS-1)'(17'(in_data.layer_index) * 17'(ns)) +
				(VNUM_BITS-1)'(in_data.slice_index);
		end
	end

	always_comb begin
		ring = CNT_BITS'(layer_q) + CNT_BITS'(CORNER_DL[cnt_q]);
		seg = CNT_BITS'(slice_q) + CNT_BITS'(CORNER_DS[cnt_q]);
		pol_num = {1'b0, ring, 31'b0} | NUM_BITS'(nl[CNT_BITS-1:1]);
		azi_num = {seg, 32'b0} | NUM_BITS'(ns[CNT_BITS-1:1]);
		issue_meta.vertex_number = VNUM_BITS'({base_q, 2'b00}) +
			VNUM_BITS'({base_q, 1'b0}) + VNUM_BITS'(cnt_q);
		issue_meta.corner = cnt_q;
		issue_meta.out_of_range = oor_q;
		issue_meta.last_corner = cnt_q == CORNER_LAST;
	end

	uvs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cell_vld_q),
		.pol_num   (pol_num),
		.pol_den   (nl),
		.azi_num   (azi_num),
		.azi_den   (ns),
		.in_meta   (issue_meta),
		.out_valid (div_vld),
		.pol_quo   (pol_quo),
		.azi_quo   (azi_quo),
		.out_meta  (div_meta)
	);

	uvs_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_vld),
		.pol_phase (pol_quo),
		.azi_phase (azi_quo),
		.in_meta   (div_meta),
		.out_valid (cor_vld),
		.pol_x     (pol_x),
		.pol_y     (pol_y),
		.pol_quad  (pol_quad),
		.azi_x     (azi_x),
		.azi_y     (azi_y),
		.azi_quad  (azi_quad),
		.out_meta  (cor_meta)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cor_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1 <= trig_round(fold_cos(pol_quad, pol_x, pol_y));
			ps_s1 <= trig_round(fold_sin(pol_quad, pol_x, pol_y));
			ac_s1 <= trig_round(fold_cos(azi_quad, azi_x, azi_y));
			as_s1 <= trig_round(fold_sin(azi_quad, azi_x, azi_y));
			meta_s1 <= cor_meta;

			dx_s2 <= TW'((PW'(ps_s1) * PW'(ac_s1) + $signed(PHALF)) >>> T);
			dy_s2 <= TW'((PW'(ps_s1) * PW'(as_s1) + $signed(PHALF)) >>> T);
			dz_s2 <= -pc_s1;
			meta_s2 <= meta_s1;

			pvx_s3 <= $signed({1'b0, radius_q}) * dx_s2;
			pvy_s3 <= $signed({1'b0, radius_q}) * dy_s2;
			pvz_s3 <= $signed({1'b0, radius_q}) * dz_s2;
			nx_s3 <= to_q15(dx_s2);
			ny_s3 <= to_q15(dy_s2);
			nz_s3 <= to_q15(dz_s2);
			meta_s3 <= meta_s2;

			out_s4.vertex_x <= to_vertex(pvx_s3);
			out_s4.vertex_y <= to_vertex(pvy_s3);
			out_s4.vertex_z <= to_vertex(pvz_s3);
			out_s4.normal_x <= nx_s3;
			out_s4.normal_y <= ny_s3;
			out_s4.normal_z <= nz_s3;
			out_s4.vertex_number <= meta_s3.vertex_number;
			out_s4.corner <= meta_s3.corner;
			out_s4.out_of_range <= meta_s3.out_of_range;
			out_s4.last_corner <= meta_s3.last_corner;
		end
	end

	assign out_valid = vld_s4;
	assign out_data = out_s4;

endmodule

@@ rtl/core/uvs_checker.sv @@
// Port-level checks for the UV sphere cell vertex generator.
// Depends on uvs_pkg; bound to the top level at the end of this file.
module uvs_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  uvs_pkg::uvs_in_t                    in_data,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  uvs_pkg::uvs_out_t                   out_data
);
	import uvs_pkg::*;

	// A stalled cell request keeps its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("request changed while stalled");

	// A stalled result request keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The corners of one cell leave back to back.
	a_cell_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_corner |=> out_valid)
		else $error("gap inside a cell");

	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_corner |=>
		out_data.corner == 3'($past(out_data.corner) + 3'd1))
		else $error("corner sequence broken");

	a_cell_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last_corner |=>
		!out_valid || out_data.corner == CORNER_FIRST)
		else $error("cell does not start at the first corner");

endmodule

bind uv_sphere_cell_vertex_generator uvs_checker u_uvs_checker (.*);
